@@ rtl/core/scanline_span_table_fill_core_defines.svh @@
// ----------------------------------------------------------------------------
// scanline_span_table_fill_core_defines.svh
// Assertion macros for the span table fill checker.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_SPAN_TABLE_FILL_CORE_DEFINES_SVH
`define SCANLINE_SPAN_TABLE_FILL_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, quiet during reset
`define SSTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, quiet during reset
`define SSTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sstf_pkg.sv @@
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared constants and types for the scanline span table fill core.
// ----------------------------------------------------------------------------
`default_nettype none

package sstf_pkg;

    localparam int DEF_ROWS      = 512;
    localparam int DEF_FRAC_BITS = 8;

    localparam int XW = 9;   // x and y coordinate width
    localparam int LW = 10;  // left extent width, holds the empty marker

    localparam logic [LW-1:0] EMPTY_LEFT = 10'd512;

    // word kinds on tuser
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // row table operations
    localparam logic [1:0] ROP_CLEAR = 2'd0;
    localparam logic [1:0] ROP_WIDEN = 2'd1;
    localparam logic [1:0] ROP_READ  = 2'd2;

    typedef struct packed {
        logic          vld;
        logic [1:0]    op;
        logic [XW-1:0] xlo;
        logic [XW-1:0] xhi;
    } t_row_req;

endpackage

`default_nettype wire

@@ rtl/core/sstf_div.sv @@
// ----------------------------------------------------------------------------
// sstf_div
// Restoring divider, one quotient bit per cycle, for the edge slope.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_div #(
    parameter int FRAC_BITS = sstf_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic [sstf_pkg::XW+FRAC_BITS-1:0]     i_num,
    input  wire logic [sstf_pkg::XW-1:0]               i_den,
    input  wire logic                                  i_neg,
    output logic                                       o_done,
    output logic signed [sstf_pkg::XW+FRAC_BITS:0]     o_quot
);

    localparam int QW = sstf_pkg::XW + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]             r_num, n_num;
    logic [sstf_pkg::XW-1:0]   r_rem, n_rem;
    logic [sstf_pkg::XW-1:0]   r_den;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic                      r_neg;

    logic [sstf_pkg::XW:0]     rem_sh;
    logic [sstf_pkg::XW:0]     rem_sub;
    logic                      ge;

    assign rem_sh  = {r_rem, r_num[QW-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_cnt  = CW'(QW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[QW-2:0], ge};
            n_rem = ge ? rem_sub[sstf_pkg::XW-1:0] : rem_sh[sstf_pkg::XW-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
            r_neg <= i_neg;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});

endmodule

`default_nettype wire

@@ rtl/core/sstf_rows.sv @@
// ----------------------------------------------------------------------------
// sstf_rows
// Per-row left and right extent memory with a two-stage widen/clear/read path.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_rows #(
    parameter int ROWS = sstf_pkg::DEF_ROWS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sstf_pkg::t_row_req         i_req,
    input  wire logic [$clog2(ROWS)-1:0]    i_addr,
    output logic [sstf_pkg::LW-1:0]         o_left,
    output logic [sstf_pkg::XW-1:0]         o_right
);

    localparam int AW = $clog2(ROWS);

    logic [sstf_pkg::LW-1:0] mem_left  [ROWS];
    logic [sstf_pkg::XW-1:0] mem_right [ROWS];

    logic [sstf_pkg::LW-1:0] r_rd_left;
    logic [sstf_pkg::XW-1:0] r_rd_right;
    sstf_pkg::t_row_req      r_s2;
    logic [AW-1:0]           r_s2_addr;

    logic                    wr_en;
    logic [sstf_pkg::LW-1:0] wr_left;
    logic [sstf_pkg::XW-1:0] wr_right;

    // second stage: merge against the row just read, or write the empty span; reads write nothing
    always_comb begin
        wr_en    = r_s2.vld && (r_s2.op != sstf_pkg::ROP_READ);
        wr_left  = r_rd_left;
        wr_right = r_rd_right;
        case (r_s2.op)
            sstf_pkg::ROP_CLEAR: begin
                wr_left  = sstf_pkg::EMPTY_LEFT;
                wr_right = '0;
            end
            sstf_pkg::ROP_WIDEN: begin
                if ({1'b0, r_s2.xlo} < r_rd_left)
                    wr_left = {1'b0, r_s2.xlo};
                if (r_s2.xhi > r_rd_right)
                    wr_right = r_s2.xhi;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_req.vld) begin
            r_rd_left  <= mem_left[i_addr];
            r_rd_right <= mem_right[i_addr];
        end
        if (wr_en) begin
            mem_left[r_s2_addr]  <= wr_left;
            mem_right[r_s2_addr] <= wr_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= i_req;
        end
        r_s2_addr <= i_addr;
    end

    assign o_left  = r_rd_left;
    assign o_right = r_rd_right;

endmodule

`default_nettype wire

@@ rtl/core/scanline_span_table_fill_core.sv @@
// ----------------------------------------------------------------------------
// scanline_span_table_fill_core
// Scanline polygon fill kept as per-row left/right extent tables.
// ----------------------------------------------------------------------------
// One word in, one word out. Word kinds on s_tuser: clear empties every row
// (left 512, right 0); edge walks its rows from lower to upper y, stepping x
// in signed fixed point with SLOPE_FRACTION_BITS fraction bits, and widens
// each row's extent; read returns one row's span with a non-empty flag. Clear
// and edge answer with zero span fields, as does the unused kind 3, which
// touches nothing. A clear writes one row per cycle; a sloped edge first runs
// the bit-serial slope divider and then walks its rows; a horizontal edge walks
// its rows at once; a read fetches its row. Clear, edge and read then pass the
// wait and done states before the answer is presented. The row walk is paced by
// the single read-modify-write path into the extent memory, one row a cycle.
// The block takes one word at a time; s_tready is high only when idle, and a
// new word may be taken while the previous answer still sits in the output
// register. After reset the tables are swept empty, and no word is accepted
// during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_span_table_fill_core #(
    parameter int ROWS                = sstf_pkg::DEF_ROWS,
    parameter int SLOPE_FRACTION_BITS = sstf_pkg::DEF_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x_start[8:0], y_start[17:9], x_end[26:18], y_end[35:27], row[44:36]
    input  wire logic [47:0] s_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // span_left[9:0], span_right[18:10], span_valid[19]
    output logic [23:0]      m_tdata,
    // reply_kind[1:0]
    output logic [1:0]       m_tuser
);

    localparam int XW  = sstf_pkg::XW;
    localparam int LW  = sstf_pkg::LW;
    localparam int F   = SLOPE_FRACTION_BITS;
    localparam int QW  = XW + F;       // slope magnitude width
    localparam int ACW = QW + 1;       // signed accumulator / slope width
    localparam int AW  = $clog2(ROWS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // input fields
    logic [XW-1:0] in_xs, in_ys, in_xe, in_ye, in_row;
    assign in_xs  = s_tdata[8:0];
    assign in_ys  = s_tdata[17:9];
    assign in_xe  = s_tdata[26:18];
    assign in_ye  = s_tdata[35:27];
    assign in_row = s_tdata[44:36];

    // endpoints ordered so that y0 <= y1
    logic          swap, flat, dneg;
    logic [XW-1:0] ox0, oy0, ox1, oy1, adx, dy;
    assign swap = (in_ys > in_ye);
    assign ox0  = swap ? in_xe : in_xs;
    assign oy0  = swap ? in_ye : in_ys;
    assign ox1  = swap ? in_xs : in_xe;
    assign oy1  = swap ? in_ys : in_ye;
    assign flat = (oy0 == oy1);
    assign dneg = (ox1 < ox0);
    assign adx  = dneg ? (ox0 - ox1) : (ox1 - ox0);
    assign dy   = oy1 - oy0;

    logic accept, div_start, div_done;
    logic signed [ACW-1:0] div_quot;

    // state
    logic [2:0]            r_state, n_state;
    logic                  r_silent, n_silent;
    logic [1:0]            r_kind, n_kind;
    logic                  r_flat, n_flat;
    logic                  r_oob, n_oob;
    logic [XW-1:0]         r_xlo, n_xlo;
    logic [XW-1:0]         r_xhi, n_xhi;
    logic [XW-1:0]         r_y, n_y;
    logic [XW-1:0]         r_y1, n_y1;
    logic signed [ACW-1:0] r_acc, n_acc;
    logic signed [ACW-1:0] r_slope, n_slope;
    logic [AW-1:0]         r_cnt, n_cnt;
    logic [LW-1:0]         r_sp_left, n_sp_left;
    logic [XW-1:0]         r_sp_right, n_sp_right;
    logic                  r_m_tvalid, n_m_tvalid;
    logic [23:0]           r_m_tdata, n_m_tdata;
    logic [1:0]            r_m_tuser, n_m_tuser;

    // row table port
    sstf_pkg::t_row_req    row_req;
    logic [AW-1:0]         row_addr;
    logic [LW-1:0]         row_left;
    logic [XW-1:0]         row_right;

    logic [XW-1:0]         walk_x;
    logic                  y_in_tab;
    logic                  sp_valid;

    assign s_tready  = (r_state == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign div_start = accept && (s_tuser == sstf_pkg::KIND_EDGE) && !flat;

    // floor of the accumulator, clamped below at zero; it never exceeds 511
    assign walk_x   = r_acc[ACW-1] ? '0 : r_acc[F+XW-1:F];
    assign y_in_tab = (32'(r_y) < 32'(ROWS));
    assign sp_valid = (r_sp_left <= {1'b0, r_sp_right});

    sstf_div #(
        .FRAC_BITS (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({adx, {F{1'b0}}}),
        .i_den   (dy),
        .i_neg   (dneg),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    sstf_rows #(
        .ROWS (ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (row_req),
        .i_addr  (row_addr),
        .o_left  (row_left),
        .o_right (row_right)
    );

    // row table requests
    always_comb begin
        row_req  = '0;
        row_addr = AW'(r_y);
        case (r_state)
            ST_CLEAR: begin
                row_req.vld = 1'b1;
                row_req.op  = sstf_pkg::ROP_CLEAR;
                row_addr    = r_cnt;
            end
            ST_WALK: begin
                row_req.vld = y_in_tab;
                row_req.op  = sstf_pkg::ROP_WIDEN;
                row_req.xlo = r_flat ? r_xlo : walk_x;
                row_req.xhi = r_flat ? r_xhi : walk_x;
            end
            ST_READ: begin
                row_req.vld = !r_oob;
                row_req.op  = sstf_pkg::ROP_READ;
            end
            default: begin
                row_req = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_silent   = r_silent;
        n_kind     = r_kind;
        n_flat     = r_flat;
        n_oob      = r_oob;
        n_xlo      = r_xlo;
        n_xhi      = r_xhi;
        n_y        = r_y;
        n_y1       = r_y1;
        n_acc      = r_acc;
        n_slope    = r_slope;
        n_cnt      = r_cnt;
        n_sp_left  = r_sp_left;
        n_sp_right = r_sp_right;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;

        if (r_m_tvalid && m_tready)
            n_m_tvalid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind   = s_tuser;
                    n_silent = 1'b0;
                    n_flat   = flat;
                    n_xlo    = dneg ? ox1 : ox0;
                    n_xhi    = dneg ? ox0 : ox1;
                    n_y      = oy0;
                    n_y1     = oy1;
                    n_acc    = $signed({1'b0, ox0, {F{1'b0}}});
                    n_cnt    = '0;
                    case (s_tuser)
                        sstf_pkg::KIND_CLEAR: n_state = ST_CLEAR;
                        sstf_pkg::KIND_EDGE:  n_state = flat ? ST_WALK : ST_DIV;
                        sstf_pkg::KIND_READ: begin
                            n_y     = in_row;
                            n_oob   = !(32'(in_row) < 32'(ROWS));
                            n_state = ST_READ;
                        end
                        default:              n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == AW'(ROWS - 1))
                    n_state = ST_WAIT;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_slope = div_quot;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                n_acc = r_acc + r_slope;
                n_y   = r_y + 1'b1;
                if (r_y == r_y1)
                    n_state = ST_WAIT;
            end
            ST_READ: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                // last write retires here; read data is on the table port
                n_sp_left  = r_oob ? sstf_pkg::EMPTY_LEFT : row_left;
                n_sp_right = r_oob ? '0 : row_right;
                n_state    = r_silent ? ST_IDLE : ST_DONE;
            end
            ST_DONE: begin
                if (!r_m_tvalid || m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tuser  = r_kind;
                    n_m_tdata  = (r_kind == sstf_pkg::KIND_READ)
                               ? {4'b0, sp_valid, r_sp_right, r_sp_left} : '0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;   // sweep the tables empty, no answer
            r_silent   <= 1'b1;
            r_cnt      <= '0;
            r_oob      <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_silent   <= n_silent;
            r_cnt      <= n_cnt;
            r_oob      <= n_oob;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_flat     <= n_flat;
        r_xlo      <= n_xlo;
        r_xhi      <= n_xhi;
        r_y        <= n_y;
        r_y1       <= n_y1;
        r_acc      <= n_acc;
        r_slope    <= n_slope;
        r_sp_left  <= n_sp_left;
        r_sp_right <= n_sp_right;
        r_m_tdata  <= n_m_tdata;
        r_m_tuser  <= n_m_tuser;
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

endmodule

`default_nettype wire

@@ rtl/core/sstf_checker.sv @@
// ----------------------------------------------------------------------------
// sstf_checker
// Port-level checks for the scanline span table fill core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scanline_span_table_fill_core_defines.svh"

module sstf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled answer holds
    `SSTF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "answer changed while stalled")

    // one word in flight: busy straight after acceptance
    `SSTF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "ready held high after accept")

    // only reads carry a span
    `SSTF_ASSERT_NOW(a_nonread_zero, m_tvalid && (m_tuser != sstf_pkg::KIND_READ), m_tdata == 24'd0, "non-read answer carries span data")

    // flag agrees with the span, pad bits clear
    `SSTF_ASSERT_NOW(a_span_flag, m_tvalid && (m_tuser == sstf_pkg::KIND_READ), (m_tdata[19] == (m_tdata[9:0] <= 10'(m_tdata[18:10]))) && (m_tdata[23:20] == 4'd0), "span flag disagrees with span")

endmodule

bind scanline_span_table_fill_core sstf_checker u_sstf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
